[hw/rtl/gjdc_pkg.sv]
// ----------------------------------------------------------------------------
// gjdc_pkg
// Shared constants and month-table functions of the Gregorian / Jalali date converter.
// ----------------------------------------------------------------------------
package gjdc_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned OYearW = 13;
  localparam int unsigned MonW   = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DaysW  = 22;

  localparam logic CmdToJalali    = 1'b0;
  localparam logic CmdToGregorian = 1'b1;

  // Cumulative days before month m (index m-1), common year.
  function automatic logic [8:0] greg_cum(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] jal_cum(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd62;
      4'd3:    r = 9'd93;
      4'd4:    r = 9'd124;
      4'd5:    r = 9'd155;
      4'd6:    r = 9'd186;
      4'd7:    r = 9'd216;
      4'd8:    r = 9'd246;
      4'd9:    r = 9'd276;
      4'd10:   r = 9'd306;
      default: r = 9'd336;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] greg_len(input logic [3:0] idx, input logic leap);
    logic [4:0] r;
    case (idx)
      4'd1:                          r = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:       r = 5'd30;
      default:                       r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] jal_len(input logic [3:0] idx);
    logic [4:0] r;
    if (idx < 4'd6) r = 5'd31;
    else if (idx < 4'd11) r = 5'd30;
    else r = 5'd29;
    return r;
  endfunction

endpackage

[hw/rtl/gregorian_jalali_date_converter_top.sv]
// ----------------------------------------------------------------------------
// gregorian_jalali_date_converter_top
// Converts one date per item between Gregorian and Jalali calendars.
// ----------------------------------------------------------------------------
// channel | handshake             | payload
// in      | in_valid / in_ready   | cmd, in_year, in_month, in_day
// out     | out_valid / out_ready | out_year, out_month, out_day, out_of_range
//
// Gregorian to Jalali takes longest, as it steps through the 33-year loop;
// Jalali to Gregorian steps through the 400-, 100-, 4- and 1-year loops instead.
// A bad month, zero day or year before the epoch year is flagged in the cycle
// after accept. A Gregorian date in the epoch year but before the epoch day
// is flagged from S_SUB, after S_DIV and S_BASE.
// in_ready is high only while idle; the result is held until out_ready.
// rst is synchronous and returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
module gregorian_jalali_date_converter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [gjdc_pkg::YearW-1:0]    in_year,
  input  logic [gjdc_pkg::MonW-1:0]     in_month,
  input  logic [gjdc_pkg::DayW-1:0]     in_day,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gjdc_pkg::OYearW-1:0]   out_year,
  output logic [gjdc_pkg::MonW-1:0]     out_month,
  output logic [gjdc_pkg::DayW-1:0]     out_day,
  output logic                          out_of_range
);
  import gjdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_BASE, S_SUB, S_J33, S_G400, S_G100, S_G4, S_Y1, S_MON, S_DONE
  } state_t;

  state_t              state;
  logic                dir;
  logic [OYearW-1:0]   yr;       // relative source year, then target year
  logic [MonW-1:0]     mon;
  logic [DayW-1:0]     dd;
  logic [DaysW-1:0]    days;
  logic [3:0]          idx;
  logic                leap;
  logic [10:0]         lcnt;     // leap days before the source year
  logic                gl;       // source Gregorian year is leap

  // shared subtractor
  logic [DaysW-1:0]    sub_b;
  logic [DaysW:0]      diff;
  logic                ge;
  logic [4:0]          mlen;

  always_comb begin
    mlen  = dir ? greg_len(idx, leap) : jal_len(idx);
    sub_b = '0;
    unique case (state)
      S_SUB:   sub_b = DaysW'(79);
      S_J33:   sub_b = DaysW'(12053);
      S_G400:  sub_b = DaysW'(146097);
      S_G100:  sub_b = DaysW'(36524);
      S_G4:    sub_b = DaysW'(1461);
      S_Y1:    sub_b = DaysW'(365);
      S_MON:   sub_b = DaysW'(mlen);
      default: sub_b = '0;
    endcase
    diff = {1'b0, days} - {1'b0, sub_b};
    ge   = ~diff[DaysW];
  end

  // leap-day count of the relative year; quotients by reciprocal multiply,
  // exact for dividends below 4096
  logic [OYearW-1:0] ry, ry3, ry99, ry399, r100, r33;
  logic [25:0]       p99, p399, p100, p33;
  logic [6:0]        q99, q100;
  logic [4:0]        q399;
  logic [8:0]        q33;
  logic [10:0]       lcnt_g, lcnt_j;
  logic              gleap;
  always_comb begin
    ry     = yr;
    ry3    = ry + OYearW'(3);
    ry99   = ry + OYearW'(99);
    ry399  = ry + OYearW'(399);
    p99    = 26'(ry99) * 26'(5243);    // /100
    p399   = 26'(ry399) * 26'(5243);   // /400
    p100   = 26'(ry) * 26'(5243);      // /100
    p33    = 26'(ry) * 26'(3972);      // /33
    q99    = p99[25:19];
    q100   = p100[25:19];
    q399   = p399[25:21];
    q33    = p33[25:17];
    r100   = ry - OYearW'(q100) * OYearW'(100);
    r33    = ry - OYearW'(q33) * OYearW'(33);
    gleap  = (ry[1:0] == 2'b00 && r100 != '0) || (r100 == '0 && q100[1:0] == 2'b00);
    lcnt_g = 11'(ry3 >> 2) - 11'(q99) + 11'(q399);
    lcnt_j = 11'({q33, 3'b000}) + 11'((r33 + OYearW'(3)) >> 2);
  end

  // day count of year start plus month offset
  logic [DaysW-1:0]  base;
  always_comb begin
    if (!dir)
      base = DaysW'(ry) * DaysW'(365) + DaysW'(lcnt) + DaysW'(greg_cum(mon - 4'd1))
           + DaysW'(mon > 4'd2 && gl) + DaysW'(dd) - DaysW'(1);
    else
      base = DaysW'(ry) * DaysW'(365) + DaysW'(lcnt) + DaysW'(jal_cum(mon - 4'd1))
           + DaysW'(dd) - DaysW'(1) + DaysW'(79);
  end

  logic bad_in;
  assign bad_in = in_month == '0 || in_month > 4'd12 || in_day == '0 ||
                  (cmd == CmdToJalali ? in_year < 12'd1600 : in_year < 12'd979);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dir <= cmd;
            mon <= in_month;
            dd  <= in_day;
            yr  <= OYearW'(in_year) - (cmd == CmdToJalali ? OYearW'(1600) : OYearW'(979));
            if (bad_in) begin
              out_year <= '0; out_month <= '0; out_day <= '0;
              out_of_range <= 1'b1; out_valid <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          lcnt <= dir ? lcnt_j : lcnt_g;
          gl <= gleap;
          state <= S_BASE;
        end
        S_BASE: begin
          days <= base;
          idx <= '0;
          leap <= 1'b1;
          if (dir) begin
            yr <= OYearW'(1600);
            state <= S_G400;
          end else begin
            yr <= OYearW'(979);
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            state <= S_J33;
          end else begin
            out_year <= '0; out_month <= '0; out_day <= '0;
            out_of_range <= 1'b1; out_valid <= 1'b1;
            state <= S_DONE;
          end
        end
        S_J33: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            yr <= yr + OYearW'(33);
          end else state <= S_G4;
        end
        S_G400: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            yr <= yr + OYearW'(400);
          end else if (days >= DaysW'(36525)) begin
            days <= days - DaysW'(1);
            state <= S_G100;
          end else state <= S_G4;
        end
        S_G100: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            yr <= yr + OYearW'(100);
          end else begin
            if (days >= DaysW'(365)) days <= days + DaysW'(1);
            else leap <= 1'b0;
            state <= S_G4;
          end
        end
        S_G4: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            yr <= yr + OYearW'(4);
          end else if (days >= DaysW'(366)) begin
            days <= days - DaysW'(1);
            leap <= 1'b0;
            state <= S_Y1;
          end else state <= S_MON;
        end
        S_Y1: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            yr <= yr + OYearW'(1);
          end else state <= S_MON;
        end
        S_MON: begin
          if (ge && idx < 4'd11) begin
            days <= diff[DaysW-1:0];
            idx <= idx + 4'd1;
          end else begin
            out_year <= yr;
            out_month <= idx + 4'd1;
            out_day <= DayW'(days) + DayW'(1);
            out_of_range <= 1'b0;
            out_valid <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = state == S_IDLE;

  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == S_DONE)) else $error("out_valid out of step with state");
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> out_year == '0 && out_month == '0 && out_day == '0)
    else $error("flagged item has nonzero fields");
  a_month_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> out_month != '0 && out_month <= 4'd12 && out_day != '0)
    else $error("bad month or day in result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("ready while busy");
endmodule

[tb/sv/gjdc_checker.sv]
// ----------------------------------------------------------------------------
// gjdc_checker
// Watches both channels of the date converter, predicts each converted date
// and compares it field by field with the item the block returns.
// ----------------------------------------------------------------------------
module gjdc_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        cmd,
  input  logic [gjdc_pkg::YearW-1:0]  in_year,
  input  logic [gjdc_pkg::MonW-1:0]   in_month,
  input  logic [gjdc_pkg::DayW-1:0]   in_day,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [gjdc_pkg::OYearW-1:0] out_year,
  input  logic [gjdc_pkg::MonW-1:0]   out_month,
  input  logic [gjdc_pkg::DayW-1:0]   out_day,
  input  logic                        out_of_range,
  output int                          fail_count,
  output int                          pending_dates,
  output int                          flagged_seen,
  output int                          converted_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import gjdc_pkg::*;

  typedef struct packed {
    logic [OYearW-1:0] year;
    logic [MonW-1:0]   month;
    logic [DayW-1:0]   day;
    logic              bad;
  } date_t;

  date_t expected_dates[$];

  function automatic int unsigned greg_days(int unsigned i, bit leap);
    int unsigned t[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    return t[i] + ((i == 1 && leap) ? 1 : 0);
  endfunction

  function automatic int unsigned jal_days(int unsigned i);
    int unsigned t[12] = '{31, 31, 31, 31, 31, 31, 30, 30, 30, 30, 30, 29};
    return t[i];
  endfunction

  function automatic date_t convert_date(logic c, int unsigned y, int unsigned m,
                                         int unsigned d);
    date_t r;
    int unsigned gy, jy, days, i, len;
    bit leap;
    r = '0;
    r.bad = 1'b1;
    if (m < 1 || m > 12 || d == 0) return r;
    if (c == CmdToJalali) begin
      if (y < 1600) return r;
      gy = y - 1600;
      days = 365 * gy + (gy + 3) / 4 - (gy + 99) / 100 + (gy + 399) / 400;
      for (i = 0; i + 1 < m; i++) days += greg_days(i, 0);
      if (m > 2 && ((gy % 4 == 0 && gy % 100 != 0) || gy % 400 == 0)) days += 1;
      days += d - 1;
      if (days < 79) return r;
      days -= 79;
      jy = 979 + 33 * (days / 12053);
      days %= 12053;
      jy += 4 * (days / 1461);
      days %= 1461;
      if (days >= 366) begin
        jy += (days - 1) / 365;
        days = (days - 1) % 365;
      end
      for (i = 0; i < 11 && days >= jal_days(i); i++) days -= jal_days(i);
      r.year = jy[OYearW-1:0];
    end else begin
      if (y < 979) return r;
      jy = y - 979;
      days = 365 * jy + (jy / 33) * 8 + (jy % 33 + 3) / 4;
      for (i = 0; i + 1 < m; i++) days += jal_days(i);
      days += d - 1 + 79;
      gy = 1600 + 400 * (days / 146097);
      days %= 146097;
      leap = 1;
      if (days >= 36525) begin
        days -= 1;
        gy += 100 * (days / 36524);
        days %= 36524;
        if (days >= 365) days += 1;
        else leap = 0;
      end
      gy += 4 * (days / 1461);
      days %= 1461;
      if (days >= 366) begin
        leap = 0;
        days -= 1;
        gy += days / 365;
        days %= 365;
      end
      for (i = 0; i < 11; i++) begin
        len = greg_days(i, leap);
        if (days < len) break;
        days -= len;
      end
      r.year = gy[OYearW-1:0];
    end
    r.month = 4'(i + 1);
    r.day = 5'(days + 1);
    r.bad = 1'b0;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending_dates = 0;
    flagged_seen = 0;
    converted_seen = 0;
  end

  always @(posedge clk) begin
    date_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_dates.push_back(convert_date(cmd, in_year, in_month, in_day));
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected item %0d-%0d-%0d flag %0b", $time,
                   out_year, out_month, out_day, out_of_range);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          if (out_of_range) flagged_seen++;
          else converted_seen++;
          if (want.year !== out_year || want.month !== out_month ||
              want.day !== out_day || want.bad !== out_of_range) begin
            $display("%0t: expected %0d-%0d-%0d flag %0b, got %0d-%0d-%0d flag %0b",
                     $time, want.year, want.month, want.day, want.bad,
                     out_year, out_month, out_day, out_of_range);
            fail_count++;
          end
        end
      end
    end
    pending_dates = expected_dates.size();
  end
endmodule

[tb/sv/gregorian_jalali_date_converter_top_tb.sv]
// ----------------------------------------------------------------------------
// gregorian_jalali_date_converter_top_tb
// Drives directed and random dates in both directions through the converter
// with bursty input and stalled output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gregorian_jalali_date_converter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gjdc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [YearW-1:0] in_year = '0;
  logic [MonW-1:0] in_month = '0;
  logic [DayW-1:0] in_day = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OYearW-1:0] out_year;
  logic [MonW-1:0] out_month;
  logic [DayW-1:0] out_day;
  logic out_of_range;
  int fail_count, pending_dates, flagged_seen, converted_seen;
  bit stim_done = 1'b0;

  always #2 clk = ~clk;

  gregorian_jalali_date_converter_top dut (.*);
  gjdc_checker u_checker (.*);

  // receiver stall pattern: modes of always ready, light and heavy stalls, and alternating ready
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic send_date(logic c, logic [YearW-1:0] y, logic [MonW-1:0] m,
                           logic [DayW-1:0] d);
    cmd <= c;
    in_year <= y;
    in_month <= m;
    in_day <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_date();
    int k;
    logic c;
    c = 1'($urandom_range(0, 1));
    k = int'($urandom_range(0, 19));
    if (k < 15)
      send_date(c, c ? YearW'($urandom_range(979, 4095)) : YearW'($urandom_range(1600, 4095)),
                MonW'($urandom_range(1, 12)), DayW'($urandom_range(1, 31)));
    else if (k < 17)
      send_date(c, c ? YearW'($urandom_range(979, 1100)) : YearW'($urandom_range(1600, 1700)),
                MonW'($urandom_range(1, 12)), DayW'($urandom_range(1, 31)));
    else
      send_date(c, YearW'($urandom()), MonW'($urandom()), DayW'($urandom()));
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // field extremes, epoch edges, bad month and zero day
    send_date(CmdToJalali, 12'd1600, 4'd3, 5'd20);
    send_date(CmdToJalali, 12'd1600, 4'd3, 5'd19);
    send_date(CmdToJalali, 12'd1599, 4'd12, 5'd31);
    send_date(CmdToJalali, 12'd1600, 4'd1, 5'd1);
    send_date(CmdToJalali, 12'd4095, 4'd12, 5'd31);
    send_date(CmdToJalali, 12'd2000, 4'd2, 5'd29);
    send_date(CmdToJalali, 12'd2024, 4'd2, 5'd31);
    send_date(CmdToJalali, 12'd2023, 4'd0, 5'd5);
    send_date(CmdToJalali, 12'd2023, 4'd13, 5'd5);
    send_date(CmdToJalali, 12'd2023, 4'd15, 5'd5);
    send_date(CmdToJalali, 12'd2023, 4'd6, 5'd0);
    send_date(CmdToJalali, 12'd0, 4'd1, 5'd1);
    send_date(CmdToGregorian, 12'd979, 4'd1, 5'd1);
    send_date(CmdToGregorian, 12'd978, 4'd12, 5'd29);
    send_date(CmdToGregorian, 12'd4095, 4'd12, 5'd31);
    send_date(CmdToGregorian, 12'd1403, 4'd12, 5'd30);
    send_date(CmdToGregorian, 12'd1402, 4'd1, 5'd1);
    send_date(CmdToGregorian, 12'd1402, 4'd0, 5'd1);
    send_date(CmdToGregorian, 12'd1402, 4'd14, 5'd1);
    send_date(CmdToGregorian, 12'd1402, 4'd7, 5'd0);
    send_date(CmdToGregorian, 12'd0, 4'd15, 5'd31);
    send_date(CmdToGregorian, 12'd1379, 4'd10, 5'd31);
    in_valid <= 1'b0;
    n = 0;
    while (n < 1530) begin
      repeat ($urandom_range(1, 12)) begin
        random_date();
        n++;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
    in_valid <= 1'b0;
    while (pending_dates != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("converted %0d dates and %0d flagged inputs in both directions",
             converted_seen, flagged_seen);
    if (fail_count == 0 && pending_dates == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
